// ----- sv/lt_pkg.sv -----
// lt_pkg: shared types, codes and lookup functions of the line tokenizer.
// No dependencies; used by lt_core and line_tokenizer.
package lt_pkg;

  localparam logic [1:0] KIND_TOKEN = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [3:0] TT_COMMA  = 4'd0;
  localparam logic [3:0] TT_BANG   = 4'd1;
  localparam logic [3:0] TT_AT     = 4'd2;
  localparam logic [3:0] TT_SLASH  = 4'd3;
  localparam logic [3:0] TT_INSTR  = 4'd4;
  localparam logic [3:0] TT_SHARP  = 4'd5;
  localparam logic [3:0] TT_COLON  = 4'd6;
  localparam logic [3:0] TT_INT    = 4'd7;
  localparam logic [3:0] TT_FLOAT  = 4'd8;
  localparam logic [3:0] TT_STRING = 4'd9;

  localparam logic [4:0] M_EMPTY  = 5'd0;
  localparam logic [4:0] M_BANG   = 5'd1;
  localparam logic [4:0] M_COLON  = 5'd2;
  localparam logic [4:0] M_SLASH  = 5'd3;
  localparam logic [4:0] M_SHARP  = 5'd4;
  localparam logic [4:0] M_SLASH2 = 5'd5;
  localparam logic [4:0] M_INSTR  = 5'd6;
  localparam logic [4:0] M_INT    = 5'd7;
  localparam logic [4:0] M_FLOAT  = 5'd8;
  localparam logic [4:0] M_OTHER  = 5'd9;
  localparam logic [4:0] M_QUOTE  = 5'd10;
  localparam logic [4:0] M_WORD   = 5'd16;
  localparam logic [4:0] M_WORD_DONE = 5'd23;

  localparam logic [2:0] L_NONE  = 3'd0;
  localparam logic [2:0] L_INSTR = 3'd1;
  localparam logic [2:0] L_SHARP = 3'd2;
  localparam logic [2:0] L_INC2  = 3'd3;
  localparam logic [2:0] L_INC3  = 3'd4;
  localparam logic [2:0] L_DROP  = 3'd5;

  localparam logic [1:0] LK_DROP    = 2'd0;
  localparam logic [1:0] LK_INSTR   = 2'd1;
  localparam logic [1:0] LK_INCLUDE = 2'd2;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_MIXED = 2'd1;
  localparam logic [1:0] ERR_UNTERM = 2'd2;

  localparam logic [1:0] GM_NONE = 2'd0;
  localparam logic [1:0] GM_OP   = 2'd1;
  localparam logic [1:0] GM_NUM  = 2'd2;

  localparam int MaxRes = 4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] col;
    logic [15:0] len;
    logic [3:0]  ttype;
    logic [15:0] row;
    logic [1:0]  lkind;
    logic [15:0] indent;
    logic [1:0]  err;
  } rec_t;

  typedef struct packed {
    rec_t [3:0] r;
    logic [2:0] n;
  } bat_t;

  function automatic logic [7:0] inc_char(input logic [2:0] k);
    logic [7:0] c;
    unique case (k)
      3'd0: c = "i";
      3'd1: c = "n";
      3'd2: c = "c";
      3'd3: c = "l";
      3'd4: c = "u";
      3'd5: c = "d";
      3'd6: c = "e";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] type_of(input logic [4:0] m);
    logic [3:0] t;
    unique case (m)
      M_BANG:  t = TT_BANG;
      M_SLASH: t = TT_SLASH;
      M_INSTR: t = TT_INSTR;
      M_SHARP: t = TT_SHARP;
      M_COLON: t = TT_COLON;
      M_INT:   t = TT_INT;
      M_FLOAT: t = TT_FLOAT;
      default: t = TT_STRING;
    endcase
    return t;
  endfunction

  function automatic logic is_op(input logic [7:0] b);
    return b == "!" || b == ":" || b == "/" || b == "#";
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_num(input logic [7:0] b);
    return is_digit(b) || b == ".";
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_standalone(input logic [7:0] b);
    return b == "(" || b == ")" || b == "{" || b == "}" || b == "[" ||
           b == "]" || b == "@" || b == ",";
  endfunction

endpackage

// ----- sv/lt_core.sv -----
// lt_core: lexer state registers and the single-pass next-state and result logic.
// Depends on lt_pkg; produces up to four records per accepted byte.
module lt_core #(
  parameter int COLUMN_BITS = 16,
  parameter int ROW_BITS    = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          acc_i,
  input  logic [7:0]    byte_i,
  input  logic          eot_i,
  output lt_pkg::bat_t  bat_o
);
  import lt_pkg::*;

  typedef struct packed {
    logic [7:0]             fib;
    logic                   ls;
    logic [15:0]            ind;
    logic [COLUMN_BITS-1:0] col;
    logic [ROW_BITS-1:0]    row;
    logic [COLUMN_BITS-1:0] ps;
    logic [15:0]            pl;
    logic [7:0]             oq;
    logic [1:0]             gm;
    logic                   esc;
    logic [4:0]             tm;
    logic [2:0]             lm;
    logic                   halt;
  } st_t;

  st_t st_q, st_d;
  bat_t bat;

  function automatic logic [15:0] c16(input logic [COLUMN_BITS-1:0] c);
    logic [31:0] e;
    e = 32'(c);
    return e[15:0];
  endfunction

  function automatic logic [15:0] r16(input logic [ROW_BITS-1:0] r);
    logic [31:0] e;
    e = 32'(r);
    return e[15:0];
  endfunction

  function automatic logic [COLUMN_BITS-1:0] col_inc(input logic [COLUMN_BITS-1:0] c);
    return (c != '1) ? c + 1'b1 : c;
  endfunction

  function automatic void emit(inout bat_t b, input rec_t r);
    if (b.n < 3'(MaxRes)) begin
      b.r[b.n[1:0]] = r;
      b.n = b.n + 3'd1;
    end
  endfunction

  function automatic rec_t mk(input logic [1:0] kind, input logic [15:0] col,
                              input logic [15:0] len, input logic [3:0] tt,
                              input logic [15:0] row, input logic [1:0] lk,
                              input logic [15:0] ind, input logic [1:0] err);
    rec_t r;
    r.kind = kind; r.col = col; r.len = len; r.ttype = tt;
    r.row = row; r.lkind = lk; r.indent = ind; r.err = err;
    return r;
  endfunction

  function automatic void len_add(inout st_t s, input logic [1:0] k);
    logic [16:0] v;
    v = {1'b0, s.pl} + 17'(k);
    s.pl = v[16] ? 16'hFFFF : v[15:0];
  endfunction

  function automatic void line_feed(inout st_t s, input logic [3:0] t, input logic [4:0] m);
    unique case (s.lm)
      L_NONE:  s.lm = (t == TT_INSTR) ? L_INSTR : ((t == TT_SHARP) ? L_SHARP : L_DROP);
      L_SHARP: s.lm = (m == M_WORD_DONE) ? L_INC2 : L_DROP;
      L_INC2:  s.lm = (m == M_QUOTE) ? L_INC3 : L_DROP;
      L_INC3:  s.lm = L_DROP;
      default: s.lm = s.lm;
    endcase
  endfunction

  function automatic void flush(inout st_t s, inout bat_t b);
    logic [3:0] t;
    t = type_of(s.tm);
    if (s.pl != 16'd0) begin
      emit(b, mk(KIND_TOKEN, c16(s.ps), s.pl, t, r16(s.row), LK_DROP, 16'd0, ERR_NONE));
      line_feed(s, t, s.tm);
    end
    s.pl = 16'd0;
    s.tm = M_EMPTY;
  endfunction

  function automatic void clear_line(inout st_t s);
    s.ls = 1'b1; s.ind = '0; s.col = '0; s.ps = '0; s.pl = '0; s.oq = '0;
    s.gm = GM_NONE; s.esc = 1'b0; s.tm = M_EMPTY; s.lm = L_NONE;
  endfunction

  function automatic st_t rst_state();
    st_t s;
    s = '0;
    s.ls = 1'b1;
    return s;
  endfunction

  function automatic void line_end(inout st_t s, inout bat_t b);
    logic [1:0] k;
    if (s.halt) return;
    s.esc = 1'b0;
    if (s.oq != 8'd0) begin
      emit(b, mk(KIND_ERROR, c16(s.ps), 16'd0, 4'd0, r16(s.row), LK_DROP, 16'd0,
                 ERR_UNTERM));
      s.halt = 1'b1;
      return;
    end
    flush(s, b);
    k = (s.lm == L_INSTR) ? LK_INSTR : ((s.lm == L_INC3) ? LK_INCLUDE : LK_DROP);
    emit(b, mk(KIND_LINE, 16'd0, 16'd0, 4'd0, r16(s.row), k, s.ind, ERR_NONE));
    if (s.row != '1) s.row = s.row + 1'b1;
    clear_line(s);
  endfunction

  function automatic void op_step(inout st_t s, input logic [7:0] by);
    if (s.tm == M_EMPTY)
      s.tm = (by == "!") ? M_BANG : (by == ":") ? M_COLON : (by == "/") ? M_SLASH : M_SHARP;
    else if (s.tm == M_SLASH && by == "/") s.tm = M_SLASH2;
    else if (s.tm == M_SLASH2 && by == "#") s.tm = M_INSTR;
    else s.tm = M_OTHER;
  endfunction

  function automatic void num_step(inout st_t s, input logic [7:0] by);
    if (s.tm == M_EMPTY) s.tm = is_digit(by) ? M_INT : M_FLOAT;
    else if (s.tm == M_INT) s.tm = is_digit(by) ? M_INT : M_FLOAT;
    else if (s.tm == M_FLOAT) s.tm = is_digit(by) ? M_FLOAT : M_OTHER;
    else s.tm = M_OTHER;
  endfunction

  function automatic void word_step(inout st_t s, input logic [7:0] by);
    logic [4:0] m;
    m = (s.tm == M_EMPTY) ? M_WORD : s.tm;
    if (m >= M_WORD && m < M_WORD_DONE)
      m = (by == inc_char(m[2:0])) ? m + 5'd1 : M_OTHER;
    else
      m = M_OTHER;
    s.tm = m;
  endfunction

  function automatic void handle_byte(inout st_t s, inout bat_t b, input logic [7:0] by,
                                      input logic [COLUMN_BITS-1:0] col);
    logic [3:0] t;
    t = (by == ",") ? TT_COMMA : ((by == "@") ? TT_AT : TT_STRING);
    if (s.esc) begin
      s.esc = 1'b0;
      return;
    end
    if (s.ls) begin
      if (by == " " || by == 8'd9) begin
        if (s.fib == 8'd0) s.fib = by;
        if (s.fib != by) begin
          emit(b, mk(KIND_ERROR, 16'd0, 16'd0, 4'd0, r16(s.row), LK_DROP, 16'd0,
                     ERR_MIXED));
          s.halt = 1'b1;
          return;
        end
        if (s.ind != 16'hFFFF) s.ind = s.ind + 16'd1;
        return;
      end
      s.ls = 1'b0; s.ps = col; s.pl = '0; s.tm = M_EMPTY;
    end
    if (by == "\\") begin
      len_add(s, 2'd2);
      s.esc = 1'b1;
      if (s.tm != M_QUOTE) s.tm = M_OTHER;
      return;
    end
    if (s.oq != 8'd0) begin
      len_add(s, 2'd1);
      if (by == s.oq) begin
        s.oq = 8'd0;
        flush(s, b);
        s.ps = col_inc(col);
      end
      return;
    end
    if (s.gm != GM_NONE) begin
      if ((s.gm == GM_OP && is_op(by)) || (s.gm == GM_NUM && is_num(by))) begin
        len_add(s, 2'd1);
        if (s.gm == GM_OP) op_step(s, by); else num_step(s, by);
        return;
      end
      flush(s, b);
      s.ps = col;
      s.gm = GM_NONE;
    end
    if (is_op(by) || is_num(by)) begin
      flush(s, b);
      s.ps = col; s.pl = 16'd1;
      s.gm = is_op(by) ? GM_OP : GM_NUM;
      if (s.gm == GM_OP) op_step(s, by); else num_step(s, by);
      return;
    end
    if (by == "\"" || by == "'") begin
      flush(s, b);
      s.ps = col_inc(col); s.pl = 16'd1; s.oq = by; s.tm = M_QUOTE;
      return;
    end
    if (is_standalone(by)) begin
      flush(s, b);
      emit(b, mk(KIND_TOKEN, c16(col), 16'd1, t, r16(s.row), LK_DROP, 16'd0, ERR_NONE));
      line_feed(s, t, M_OTHER);
      s.ps = col_inc(col);
      return;
    end
    if (is_space(by)) begin
      flush(s, b);
      s.ps = col_inc(col);
      return;
    end
    len_add(s, 2'd1);
    word_step(s, by);
  endfunction

  always_comb begin
    st_t s;
    bat_t b;
    s = st_q;
    b = '0;
    if (!s.halt) begin
      if (byte_i == 8'd10) begin
        line_end(s, b);
      end else begin
        handle_byte(s, b, byte_i, s.col);
        s.col = col_inc(s.col);
      end
      if (eot_i) line_end(s, b);
    end
    if (eot_i) begin
      s.halt = 1'b0;
      s.row = '0;
      clear_line(s);
    end
    st_d = s;
    bat  = b;
  end

  assign bat_o = bat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= rst_state();
    end else if (acc_i) begin
      st_q <= st_d;
    end
  end

  a_halt_eot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && eot_i |=> !st_q.halt)
    else $error("halt survived end of text");
  a_line_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.ls |-> st_q.pl == 16'd0 && st_q.oq == 8'd0)
    else $error("pending token at line start");
  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.halt && !eot_i |-> bat.n == 3'd0)
    else $error("records while halted");

endmodule

// ----- sv/line_tokenizer.sv -----
// line_tokenizer: streaming line lexer, one text byte per transfer.
// Depends on lt_pkg and lt_core.
// One byte is accepted per cycle while the record buffer is empty or its last
// record is being taken. The lexer state and up to four records are computed
// in one pass and held in a record buffer that drains one record per cycle
// while the receiver is ready, keeping the input stalled until the last goes.
module line_tokenizer #(
  parameter int COLUMN_BITS = 16,
  parameter int ROW_BITS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // text_byte
  input  logic        s_axis_tlast_i,   // end_of_text
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // token_column, token_length, token_type, row_number, line_kind,
  // indent_count, error_code
  output logic [71:0] m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o,   // record_kind
  output logic        m_axis_tlast_o    // last_of_step
);
  import lt_pkg::*;

  bat_t       bat, bat_q;
  logic [2:0] cnt_q;
  logic [1:0] idx_q;
  logic       acc, oxf;
  rec_t       r;

  assign oxf = m_axis_tvalid_o && m_axis_tready_i;
  assign s_axis_tready_o = (cnt_q == 3'd0) || (cnt_q == 3'd1 && m_axis_tready_i);
  assign acc = s_axis_tvalid_i && s_axis_tready_o;

  lt_core #(.COLUMN_BITS(COLUMN_BITS), .ROW_BITS(ROW_BITS)) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .byte_i (s_axis_tdata_i),
    .eot_i  (s_axis_tlast_i),
    .bat_o  (bat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (acc) begin
      cnt_q <= bat.n;
      idx_q <= '0;
    end else if (oxf) begin
      cnt_q <= cnt_q - 3'd1;
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) bat_q <= bat;
  end

  assign r = bat_q.r[idx_q];
  assign m_axis_tvalid_o = cnt_q != 3'd0;
  assign m_axis_tlast_o  = cnt_q == 3'd1;
  assign m_axis_tuser_o  = r.kind;
  assign m_axis_tdata_o  = {r.err, r.indent, r.lkind, r.row, r.ttype, r.len, r.col};

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, idx_q} + cnt_q) <= 4'd4)
    else $error("record buffer overrun");
  a_no_early_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q > 3'd1 |-> !s_axis_tready_o)
    else $error("input ready with records pending");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && bat.n != 3'd0 |=> m_axis_tvalid_o && idx_q == 2'd0)
    else $error("accepted records not presented");

endmodule

// ----- tb/line_tokenizer_test.sv -----
// line_tokenizer_test: self-checking testbench for the line_tokenizer lexer.
// Depends on lt_pkg and line_tokenizer; a local predictor checks each record
// against bursty byte input and a stalling record receiver.
module line_tokenizer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lt_pkg::*;

  typedef struct {
    logic [7:0] b;
    logic       eot;
  } text_item_t;

  typedef struct {
    logic [1:0]  kind;
    logic [71:0] data;
    logic        last;
  } lex_rec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [71:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  line_tokenizer uut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  text_item_t text_q[$];
  lex_rec_t   lex_q[$];
  int step_recs, mismatches, n_tok, n_line, n_err, idle_cycles, cyc;
  bit stim_done;

  // lexer state
  logic [7:0] first_ind;
  bit         at_start, skip_esc, halted;
  int         ind_cnt, col, row, p_start, p_len;
  logic [7:0] open_q;
  logic [1:0] grp;
  logic [4:0] tmatch;
  logic [2:0] lmatch;
  string      inc_word = "include";

  function automatic int sat_col(int c);
    return c < 65535 ? c + 1 : c;
  endfunction

  function automatic void put_rec(logic [1:0] kind, int c, int len, logic [3:0] tt,
                                  logic [1:0] lk, int ind, logic [1:0] err);
    lex_rec_t r;
    if (step_recs >= MaxRes) return;
    r.kind = kind;
    r.data = {err, ind[15:0], lk, row[15:0], tt, len[15:0], c[15:0]};
    r.last = 1'b0;
    lex_q.push_back(r);
    step_recs++;
  endfunction

  function automatic void feed_line(logic [3:0] tt, logic [4:0] m);
    case (lmatch)
      L_NONE:  lmatch = tt == TT_INSTR ? L_INSTR : (tt == TT_SHARP ? L_SHARP : L_DROP);
      L_SHARP: lmatch = m == M_WORD_DONE ? L_INC2 : L_DROP;
      L_INC2:  lmatch = m == M_QUOTE ? L_INC3 : L_DROP;
      L_INC3:  lmatch = L_DROP;
      default: ;
    endcase
  endfunction

  function automatic logic [3:0] tok_type(logic [4:0] m);
    case (m)
      M_BANG:  return TT_BANG;
      M_SLASH: return TT_SLASH;
      M_INSTR: return TT_INSTR;
      M_SHARP: return TT_SHARP;
      M_COLON: return TT_COLON;
      M_INT:   return TT_INT;
      M_FLOAT: return TT_FLOAT;
      default: return TT_STRING;
    endcase
  endfunction

  function automatic void flush_tok();
    logic [3:0] t;
    if (p_len != 0) begin
      t = tok_type(tmatch);
      put_rec(KIND_TOKEN, p_start, p_len, t, LK_DROP, 0, ERR_NONE);
      feed_line(t, tmatch);
    end
    p_len = 0;
    tmatch = M_EMPTY;
  endfunction

  function automatic void add_len(int k);
    p_len = (p_len + k > 65535) ? 65535 : p_len + k;
  endfunction

  function automatic bit op_byte(logic [7:0] b);
    return b == "!" || b == ":" || b == "/" || b == "#";
  endfunction

  function automatic bit num_byte(logic [7:0] b);
    return (b >= "0" && b <= "9") || b == ".";
  endfunction

  function automatic void group_step(logic [7:0] b);
    bit dig;
    dig = b >= "0" && b <= "9";
    if (grp == GM_OP) begin
      if (tmatch == M_EMPTY)
        tmatch = b == "!" ? M_BANG : b == ":" ? M_COLON : b == "/" ? M_SLASH : M_SHARP;
      else if (tmatch == M_SLASH && b == "/") tmatch = M_SLASH2;
      else if (tmatch == M_SLASH2 && b == "#") tmatch = M_INSTR;
      else tmatch = M_OTHER;
    end else begin
      if (tmatch == M_EMPTY || tmatch == M_INT) tmatch = dig ? M_INT : M_FLOAT;
      else if (tmatch == M_FLOAT) tmatch = dig ? M_FLOAT : M_OTHER;
      else tmatch = M_OTHER;
    end
  endfunction

  function automatic void lex_byte(logic [7:0] b, int c);
    logic [3:0] t;
    if (skip_esc) begin
      skip_esc = 0;
      return;
    end
    if (at_start) begin
      if (b == " " || b == 8'd9) begin
        if (first_ind == 0) first_ind = b;
        if (first_ind != b) begin
          put_rec(KIND_ERROR, 0, 0, TT_COMMA, LK_DROP, 0, ERR_MIXED);
          halted = 1;
          return;
        end
        if (ind_cnt < 65535) ind_cnt++;
        return;
      end
      at_start = 0;
      p_start = c;
      p_len = 0;
      tmatch = M_EMPTY;
    end
    if (b == "\\") begin
      add_len(2);
      skip_esc = 1;
      if (tmatch != M_QUOTE) tmatch = M_OTHER;
      return;
    end
    if (open_q != 0) begin
      add_len(1);
      if (b == open_q) begin
        open_q = 0;
        flush_tok();
        p_start = sat_col(c);
      end
      return;
    end
    if (grp != GM_NONE) begin
      if ((grp == GM_OP && op_byte(b)) || (grp == GM_NUM && num_byte(b))) begin
        add_len(1);
        group_step(b);
        return;
      end
      flush_tok();
      p_start = c;
      grp = GM_NONE;
    end
    if (op_byte(b) || num_byte(b)) begin
      flush_tok();
      p_start = c;
      p_len = 1;
      grp = op_byte(b) ? GM_OP : GM_NUM;
      group_step(b);
    end else if (b == "\"" || b == "'") begin
      flush_tok();
      p_start = sat_col(c);
      p_len = 1;
      open_q = b;
      tmatch = M_QUOTE;
    end else if (b == "(" || b == ")" || b == "{" || b == "}" || b == "[" ||
                 b == "]" || b == "@" || b == ",") begin
      flush_tok();
      t = b == "," ? TT_COMMA : (b == "@" ? TT_AT : TT_STRING);
      put_rec(KIND_TOKEN, c, 1, t, LK_DROP, 0, ERR_NONE);
      feed_line(t, M_OTHER);
      p_start = sat_col(c);
    end else if (b == 8'd32 || (b >= 8'd9 && b <= 8'd13)) begin
      flush_tok();
      p_start = sat_col(c);
    end else begin
      add_len(1);
      if (tmatch == M_EMPTY) tmatch = M_WORD;
      if (tmatch >= M_WORD && tmatch < M_WORD_DONE)
        tmatch = b == inc_word[tmatch - M_WORD] ? tmatch + 5'd1 : M_OTHER;
      else tmatch = M_OTHER;
    end
  endfunction

  function automatic void new_line();
    at_start = 1;
    ind_cnt = 0;
    col = 0;
    p_start = 0;
    p_len = 0;
    open_q = 0;
    grp = GM_NONE;
    skip_esc = 0;
    tmatch = M_EMPTY;
    lmatch = L_NONE;
  endfunction

  function automatic void close_line();
    logic [1:0] lk;
    if (halted) return;
    skip_esc = 0;
    if (open_q != 0) begin
      put_rec(KIND_ERROR, p_start, 0, TT_COMMA, LK_DROP, 0, ERR_UNTERM);
      halted = 1;
      return;
    end
    flush_tok();
    lk = lmatch == L_INSTR ? LK_INSTR : (lmatch == L_INC3 ? LK_INCLUDE : LK_DROP);
    put_rec(KIND_LINE, 0, 0, TT_COMMA, lk, ind_cnt, ERR_NONE);
    if (row < 65535) row++;
    new_line();
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic eot);
    step_recs = 0;
    if (!halted) begin
      if (b == 8'd10) close_line();
      else begin
        lex_byte(b, col);
        col = sat_col(col);
      end
      if (eot) close_line();
    end
    if (eot) begin
      halted = 0;
      row = 0;
      new_line();
    end
    if (step_recs > 0) lex_q[lex_q.size() - 1].last = 1'b1;
  endfunction

  // stimulus helpers
  function automatic void push_text(string s, bit eot_at_end);
    text_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.b = s[i];
      it.eot = eot_at_end && (i == s.len() - 1);
      text_q.push_back(it);
    end
  endfunction

  function automatic void push_byte(logic [7:0] b, bit eot);
    text_item_t it;
    it.b = b;
    it.eot = eot;
    text_q.push_back(it);
  endfunction

  function automatic string rand_piece();
    case ($urandom_range(0, 11))
      0: return "//#";
      1: return "#";
      2: return "include";
      3: return $urandom_range(0, 1) ? "\"a\\\"b\"" : "'inc'";
      4: return "123";
      5: return "4.5.6";
      6: return "!:/";
      7: return "(@,]";
      8: return "w\\x";
      9: return "inclx";
      10: return "{}";
      default: return "/";
    endcase
  endfunction

  initial begin
    first_ind = 0;
    row = 0;
    halted = 0;
    new_line();
    push_text("//# x:1.5\n", 0);
    push_text("  #include'a\\'b'\n", 0);
    push_text(" f(@,)!=3..2 /x\n", 0);
    push_text("\tz\n", 0);
    push_text("q\n", 1);
    push_text("'open\n", 0);
    push_byte(8'h00, 0);
    push_byte(8'hFF, 1);
    push_text("a\\\nx", 1);
    while (text_q.size() < 260) begin
      string ln;
      int nind;
      ln = "";
      nind = $urandom_range(0, 3);
      for (int i = 0; i < nind; i++)
        ln = {ln, ($urandom_range(0, 19) == 0) ? "\t" : " "};
      if ($urandom_range(0, 3) == 0) ln = {ln, "# include \"f\""};
      else if ($urandom_range(0, 3) == 0) ln = {ln, "//# "};
      repeat ($urandom_range(0, 4)) begin
        ln = {ln, rand_piece()};
        if ($urandom_range(0, 2) != 0) ln = {ln, " "};
      end
      if ($urandom_range(0, 9) == 0) ln = {ln, "'unterminated"};
      foreach (ln[i]) push_byte(ln[i], 0);
      if ($urandom_range(0, 4) == 0) push_byte(8'($urandom_range(0, 255)), 0);
      case ($urandom_range(0, 9))
        0: push_byte(8'd10, 1);
        1: push_byte(8'($urandom_range(0, 255)), 1);
        default: push_byte(8'd10, 0);
      endcase
    end
    push_byte(8'd10, 1);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  int burst_left = 0, gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        predict_byte(s_axis_tdata_i, s_axis_tlast_i);
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid_i <= 1'b0;
        end else if (text_q.size() > 0) begin
          text_item_t it;
          it = text_q.pop_front();
          s_axis_tdata_i <= it.b;
          s_axis_tlast_i <= it.eot;
          s_axis_tvalid_i <= 1'b1;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 30);
            gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid_i <= 1'b0;
          stim_done = 1;
        end
      end
    end
  end

  logic [15:0] stall_pat = 16'hFFFF;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      cyc <= 0;
    end else begin
      cyc <= cyc + 1;
      if (cyc % 150 == 0)
        stall_pat = $urandom_range(0, 2) == 0 ? 16'hFFFF : 16'($urandom) | 16'h0001;
      m_axis_tready_i <= stall_pat[cyc % 16];
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        lex_rec_t e;
        if (lex_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected record kind=%0d data=%h last=%b",
                     m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o);
        end else begin
          e = lex_q.pop_front();
          case (e.kind)
            KIND_TOKEN: n_tok++;
            KIND_LINE:  n_line++;
            default:    n_err++;
          endcase
          if (e.kind !== m_axis_tuser_o || e.data[15:0] !== m_axis_tdata_o[15:0] ||
              e.data[31:16] !== m_axis_tdata_o[31:16] ||
              e.data[35:32] !== m_axis_tdata_o[35:32] ||
              e.data[51:36] !== m_axis_tdata_o[51:36] ||
              e.data[53:52] !== m_axis_tdata_o[53:52] ||
              e.data[69:54] !== m_axis_tdata_o[69:54] ||
              e.data[71:70] !== m_axis_tdata_o[71:70] || e.last !== m_axis_tlast_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp kind=%0d col=%0d len=%0d type=%0d row=%0d lk=%0d ind=%0d err=%0d last=%b | got kind=%0d col=%0d len=%0d type=%0d row=%0d lk=%0d ind=%0d err=%0d last=%b",
                       e.kind, e.data[15:0], e.data[31:16], e.data[35:32],
                       e.data[51:36], e.data[53:52], e.data[69:54], e.data[71:70], e.last,
                       m_axis_tuser_o, m_axis_tdata_o[15:0], m_axis_tdata_o[31:16],
                       m_axis_tdata_o[35:32], m_axis_tdata_o[51:36],
                       m_axis_tdata_o[53:52], m_axis_tdata_o[69:54],
                       m_axis_tdata_o[71:70], m_axis_tlast_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 3000) begin
        $display("watchdog: no transfer for %0d cycles", idle_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done && lex_q.size() == 0);
    repeat (40) @(posedge clk_i);
    $display("covered %0d token, %0d line and %0d error records; %0d mismatches",
             n_tok, n_line, n_err, mismatches);
    if (mismatches == 0 && lex_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ----- sim.f -----
sv/lt_pkg.sv
sv/lt_core.sv
sv/line_tokenizer.sv
tb/line_tokenizer_test.sv
